>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> sv/rtcp_pkg.sv
// ----------------------------------------------------------------------------
// rtcp_pkg
// types and constants shared by the rtcp report parser modules
// ----------------------------------------------------------------------------
package rtcp_pkg;

    localparam int REPORT_BLOCK_BYTES = 24;
    localparam int SENDER_INFO_BYTES  = 20;
    localparam int SHIFT_W            = (REPORT_BLOCK_BYTES - 1) * 8;
    localparam int BLOCK_W            = REPORT_BLOCK_BYTES * 8;

    localparam logic [1:0] RTP_VERSION = 2'd2;
    localparam logic [7:0] TYPE_SR     = 8'd200;
    localparam logic [7:0] TYPE_RR     = 8'd201;
    localparam logic [7:0] TYPE_MIN    = 8'd200;
    localparam logic [7:0] TYPE_MAX    = 8'd207;

    localparam logic [17:0] POS_FIRST     = 18'd0;
    localparam logic [17:0] POS_TYPE      = 18'd1;
    localparam logic [17:0] POS_LEN_HI    = 18'd2;
    localparam logic [17:0] POS_LEN_LO    = 18'd3;
    localparam logic [17:0] POS_SSRC_LAST = 18'd7;
    localparam logic [17:0] POS_MAX       = 18'h3FFFF;
    localparam logic [17:0] START_RR      = 18'd8;
    localparam logic [17:0] START_SR      = 18'(8 + SENDER_INFO_BYTES);

    localparam logic [4:0] OFF_LAST = 5'(REPORT_BLOCK_BYTES - 1);

    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_VERSION = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE    = 3'd2;
    localparam logic [2:0] ST_TRUNCATED   = 3'd3;
    localparam logic [2:0] ST_OVERFLOW    = 3'd4;

    localparam logic KIND_BLOCK  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       end_of_packet;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        logic [31:0] sender_source;
        logic [31:0] block_source;
        logic [7:0]  fraction_lost;
        logic [23:0] cumulative_lost;
        logic [31:0] highest_sequence;
        logic [31:0] arrival_jitter;
        logic [31:0] last_sender_report;
        logic [31:0] delay_since_report;
        logic [2:0]  packet_status;
        logic [4:0]  blocks_declared;
        logic        last_of_run;
    } out_t;

    typedef struct packed {
        logic [31:0] block_source;
        logic [7:0]  fraction_lost;
        logic [23:0] cumulative_lost;
        logic [31:0] highest_sequence;
        logic [31:0] arrival_jitter;
        logic [31:0] last_sender_report;
        logic [31:0] delay_since_report;
    } block_t;

    typedef struct packed {
        logic        has_block;
        logic        has_status;
        logic [31:0] sender;
        block_t      blk;
        logic [2:0]  status;
        logic [4:0]  count;
    } work_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_flags_t;

endpackage

>>> sv/rtcp_front.sv
// ----------------------------------------------------------------------------
// rtcp_front
// byte position tracking, header decode, block capture and status build
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtcp_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  rtcp_pkg::in_t    byte_data,
    input  rtcp_pkg::q_flags_t q_flags,
    output logic             push,
    output rtcp_pkg::work_t  entry
);

    logic [17:0] pos_reg, pos_next;
    logic [4:0]  count_reg, count_next;
    logic [7:0]  type_reg, type_next;
    logic [17:0] decl_reg, decl_next;
    logic [31:0] sender_reg, sender_next;
    logic [4:0]  blocks_reg, blocks_next;
    logic [2:0]  err_reg, err_next;
    logic [4:0]  off_reg, off_next;
    logic [rtcp_pkg::SHIFT_W-1:0] shift_reg, shift_next;

    logic        fire;
    logic [7:0]  b;
    logic        eop;
    logic        is_report;
    logic [17:0] start;
    logic [9:0]  need_m1;
    logic        block_hit;
    logic        block_done;
    logic        has_block;
    logic        trunc;
    logic [2:0]  status;
    logic [rtcp_pkg::BLOCK_W-1:0] full_block;

    assign byte_stall = q_flags.full;

    always_comb
    begin
        fire        = byte_valid && !q_flags.full;
        b           = byte_data.packet_byte;
        eop         = byte_data.end_of_packet;
        pos_next    = pos_reg;
        count_next  = count_reg;
        type_next   = type_reg;
        decl_next   = decl_reg;
        sender_next = sender_reg;
        blocks_next = blocks_reg;
        err_next    = err_reg;
        off_next    = off_reg;
        shift_next  = shift_reg;
        block_hit   = 1'b0;
        block_done  = 1'b0;
        is_report   = (type_reg == rtcp_pkg::TYPE_SR) || (type_reg == rtcp_pkg::TYPE_RR);
        start       = (type_reg == rtcp_pkg::TYPE_SR) ? rtcp_pkg::START_SR
                                                      : rtcp_pkg::START_RR;
        need_m1     = 10'(start - 18'd1)
                    + 10'(count_reg) * 10'(rtcp_pkg::REPORT_BLOCK_BYTES);

        if (pos_reg == rtcp_pkg::POS_FIRST)
        begin
            count_next = b[4:0];
            err_next   = (b[7:6] != rtcp_pkg::RTP_VERSION) ? rtcp_pkg::ST_BAD_VERSION
                                                           : rtcp_pkg::ST_OK;
        end
        else if (pos_reg == rtcp_pkg::POS_TYPE)
        begin
            type_next = b;
            if (err_reg == rtcp_pkg::ST_OK && (b < rtcp_pkg::TYPE_MIN || b > rtcp_pkg::TYPE_MAX))
            begin
                err_next = rtcp_pkg::ST_BAD_TYPE;
            end
        end
        else if (pos_reg == rtcp_pkg::POS_LEN_HI)
        begin
            decl_next = {10'd0, b};
        end
        else if (pos_reg == rtcp_pkg::POS_LEN_LO)
        begin
            decl_next = {decl_reg[7:0], b, 2'b11};
            if (err_reg == rtcp_pkg::ST_OK && is_report && {8'd0, need_m1} > decl_next)
            begin
                err_next = rtcp_pkg::ST_OVERFLOW;
            end
        end
        else if (pos_reg <= rtcp_pkg::POS_SSRC_LAST)
        begin
            sender_next = {sender_reg[23:0], b};
        end
        else if (err_reg == rtcp_pkg::ST_OK && is_report && pos_reg >= start
                 && blocks_reg < count_reg)
        begin
            block_hit  = 1'b1;
            shift_next = {shift_reg[rtcp_pkg::SHIFT_W-9:0], b};
            if (off_reg == rtcp_pkg::OFF_LAST)
            begin
                block_done  = 1'b1;
                off_next    = 5'd0;
                blocks_next = blocks_reg + 5'd1;
            end
            else
            begin
                off_next = off_reg + 5'd1;
            end
        end

        full_block = {shift_reg, b};
        has_block  = block_done && (full_block[191:160] != 32'd0);
        trunc      = (pos_reg < rtcp_pkg::POS_SSRC_LAST) || (pos_reg < decl_next);
        status     = err_next;
        if (err_next != rtcp_pkg::ST_BAD_VERSION && err_next != rtcp_pkg::ST_BAD_TYPE && trunc)
        begin
            status = rtcp_pkg::ST_TRUNCATED;
        end

        entry.has_block              = has_block;
        entry.has_status             = eop;
        entry.sender                 = sender_next;
        entry.blk.block_source       = full_block[191:160];
        entry.blk.fraction_lost      = full_block[159:152];
        entry.blk.cumulative_lost    = full_block[151:128];
        entry.blk.highest_sequence   = full_block[127:96];
        entry.blk.arrival_jitter     = full_block[95:64];
        entry.blk.last_sender_report = full_block[63:32];
        entry.blk.delay_since_report = full_block[31:0];
        entry.status                 = status;
        entry.count                  = count_next;
        push                         = fire && (has_block || eop);

        if (eop)
        begin
            pos_next    = 18'd0;
            count_next  = 5'd0;
            type_next   = 8'd0;
            decl_next   = 18'd0;
            sender_next = 32'd0;
            blocks_next = 5'd0;
            err_next    = rtcp_pkg::ST_OK;
            off_next    = 5'd0;
        end
        else if (pos_reg != rtcp_pkg::POS_MAX)
        begin
            pos_next = pos_reg + 18'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 18'd0;
            count_reg  <= 5'd0;
            type_reg   <= 8'd0;
            decl_reg   <= 18'd0;
            sender_reg <= 32'd0;
            blocks_reg <= 5'd0;
            err_reg    <= rtcp_pkg::ST_OK;
            off_reg    <= 5'd0;
        end
        else if (fire)
        begin
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            type_reg   <= type_next;
            decl_reg   <= decl_next;
            sender_reg <= sender_next;
            blocks_reg <= blocks_next;
            err_reg    <= err_next;
            off_reg    <= off_next;
        end
    end

    // block byte shift line
    always_ff @(posedge clk)
    begin
        if (fire && block_hit)
        begin
            shift_reg <= shift_next;
        end
    end

    `ASSERT_IMPLY(a_off_in_block, off_reg != 5'd0, err_reg == rtcp_pkg::ST_OK && blocks_reg < count_reg, "block offset outside block capture")
    `ASSERT_IMPLY(a_push_has_room, push, !q_flags.full, "push into full queue")

endmodule

>>> sv/rtcp_queue.sv
// ----------------------------------------------------------------------------
// rtcp_queue
// short work queue between front and back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtcp_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rtcp_pkg::work_t    entry,
    input  logic               pop,
    output rtcp_pkg::work_t    head,
    output rtcp_pkg::q_flags_t q_flags
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rtcp_pkg::work_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_pop;

    always_comb
    begin
        q_flags.valid = (cnt_reg != '0);
        q_flags.full  = (cnt_reg == CNT_W'(DEPTH));
        do_pop        = pop && q_flags.valid;
        head          = mem_reg[rd_reg];
        wr_next       = wr_reg;
        rd_next       = rd_reg;
        cnt_next      = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (!push && do_pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= entry;
        end
    end

    `ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH), "queue count above depth")
    `ASSERT_IMPLY(a_pop_nonempty, pop, q_flags.valid, "pop from empty queue")

endmodule

>>> sv/rtcp_back.sv
// ----------------------------------------------------------------------------
// rtcp_back
// expands queued work into block and status results, output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rtcp_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  rtcp_pkg::work_t    head,
    input  rtcp_pkg::q_flags_t q_flags,
    output logic               pop,
    output logic               result_valid,
    input  logic               result_stall,
    output rtcp_pkg::out_t     result_data
);

    logic           out_valid_reg, out_valid_next;
    rtcp_pkg::out_t out_data_reg, out_data_next;
    logic           phase_reg, phase_next;
    logic           load;
    logic           emit_block;

    always_comb
    begin
        load           = !out_valid_reg || !result_stall;
        emit_block     = head.has_block && !phase_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        phase_next     = phase_reg;
        pop            = 1'b0;

        if (load)
        begin
            out_valid_next = q_flags.valid;
            if (q_flags.valid)
            begin
                out_data_next                    = '0;
                out_data_next.sender_source      = head.sender;
                out_data_next.blocks_declared    = head.count;
                out_data_next.last_of_run        = 1'b1;
                if (emit_block)
                begin
                    out_data_next.result_kind        = rtcp_pkg::KIND_BLOCK;
                    out_data_next.block_source       = head.blk.block_source;
                    out_data_next.fraction_lost      = head.blk.fraction_lost;
                    out_data_next.cumulative_lost    = head.blk.cumulative_lost;
                    out_data_next.highest_sequence   = head.blk.highest_sequence;
                    out_data_next.arrival_jitter     = head.blk.arrival_jitter;
                    out_data_next.last_sender_report = head.blk.last_sender_report;
                    out_data_next.delay_since_report = head.blk.delay_since_report;
                    out_data_next.packet_status      = rtcp_pkg::ST_OK;
                    out_data_next.last_of_run        = !head.has_status;
                    phase_next                       = head.has_status;
                    pop                              = !head.has_status;
                end
                else
                begin
                    out_data_next.result_kind   = rtcp_pkg::KIND_STATUS;
                    out_data_next.packet_status = head.status;
                    phase_next                  = 1'b0;
                    pop                         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    `ASSERT_IMPLY(a_phase_head, phase_reg, q_flags.valid && head.has_block && head.has_status, "status phase without matching head")
    `ASSERT_NEXT(a_phase_after_block, load && q_flags.valid && emit_block && head.has_status, phase_reg && result_data.result_kind == rtcp_pkg::KIND_BLOCK, "block of a two-result beat not followed by status phase")

endmodule

>>> sv/rtcp_report_parser.sv
// ----------------------------------------------------------------------------
// rtcp_report_parser
// rtcp sender and receiver report parser, one packet byte per beat
// ----------------------------------------------------------------------------
// Takes one packet byte per cycle while byte_stall is low, with no gaps needed
// between packets. A front stage tracks the byte position, decodes the
// header and collects each 24-byte reception block in a shift line; bytes
// that finish a block with a nonzero source, and the end-of-packet byte,
// place one work entry in a short queue. The back stage turns each entry
// into one or two results through a registered output, one result per cycle
// while result_stall is low; a result passes from the queue into the output
// register. A byte that completes a block and also ends the packet yields a
// block result and then a status result, so entry-producing bytes right
// behind it can fill the queue and stall the byte input; apart from that the
// input stalls only when a stalled output lets the queue fill up.
// ----------------------------------------------------------------------------
module rtcp_report_parser
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            byte_valid,
    output logic            byte_stall,
    input  rtcp_pkg::in_t   byte_data,
    output logic            result_valid,
    input  logic            result_stall,
    output rtcp_pkg::out_t  result_data
);

    logic               push;
    logic               pop;
    rtcp_pkg::work_t    entry;
    rtcp_pkg::work_t    head;
    rtcp_pkg::q_flags_t q_flags;

    rtcp_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .q_flags    (q_flags),
        .push       (push),
        .entry      (entry)
    );

    rtcp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .entry   (entry),
        .pop     (pop),
        .head    (head),
        .q_flags (q_flags)
    );

    rtcp_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_flags      (q_flags),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

>>> test/rtcp_report_parser_tb.sv
// ----------------------------------------------------------------------------
// rtcp_report_parser_tb
// self-checking testbench for the rtcp sender and receiver report parser
// ----------------------------------------------------------------------------
// Feeds packets one byte per beat: a few short directed packets (bad version,
// bad type, truncated header, minimal receiver report, overflowing sender
// report), then mostly well-formed sender and receiver reports with random
// blocks mixed with truncated, overflowing, padded, foreign-type and noise
// packets. A scoreboard tracks the packet state byte by byte, queues the
// block and status results each byte should produce, and compares every
// result field by field. Both sides idle and stall at random, except over the
// last quarter of the run; the result side also holds off for a long stretch
// so the parser fills up and stalls its byte input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rtcp_report_parser_tb;

    localparam int ITEMS       = 1450;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN       = 10;

    class report_tracker;
        logic [17:0]    pos;
        logic [4:0]     rpt_count;
        logic [7:0]     pkt_type;
        logic [17:0]    last_index;
        logic [31:0]    sender;
        logic [7:0]     blk [rtcp_pkg::REPORT_BLOCK_BYTES];
        logic [4:0]     blocks_done;
        logic [2:0]     status;
        rtcp_pkg::out_t results_due[$];
        int             errors;

        function new();
            clear_packet();
            foreach (blk[i])
                blk[i] = '0;
            errors = 0;
        endfunction

        function void clear_packet();
            pos         = '0;
            rpt_count   = '0;
            pkt_type    = '0;
            last_index  = '0;
            sender      = '0;
            blocks_done = '0;
            status      = rtcp_pkg::ST_OK;
        endfunction

        function bit is_report();
            return pkt_type == rtcp_pkg::TYPE_SR || pkt_type == rtcp_pkg::TYPE_RR;
        endfunction

        function int block_start();
            return (pkt_type == rtcp_pkg::TYPE_SR) ? 8 + rtcp_pkg::SENDER_INFO_BYTES : 8;
        endfunction

        function logic [31:0] word(int k);
            return {blk[k], blk[k + 1], blk[k + 2], blk[k + 3]};
        endfunction

        function void note_byte(rtcp_pkg::in_t d);
            logic [7:0]     b;
            rtcp_pkg::out_t res;
            int             off;
            int             need;
            logic [31:0]    w1;
            bit             trunc;
            b = d.packet_byte;
            if (pos == rtcp_pkg::POS_FIRST)
            begin
                rpt_count = b[4:0];
                status    = (b[7:6] != rtcp_pkg::RTP_VERSION) ? rtcp_pkg::ST_BAD_VERSION
                                                              : rtcp_pkg::ST_OK;
            end
            else if (pos == rtcp_pkg::POS_TYPE)
            begin
                pkt_type = b;
                if (status == rtcp_pkg::ST_OK
                    && (b < rtcp_pkg::TYPE_MIN || b > rtcp_pkg::TYPE_MAX))
                    status = rtcp_pkg::ST_BAD_TYPE;
            end
            else if (pos == rtcp_pkg::POS_LEN_HI)
                last_index = 18'(b);
            else if (pos == rtcp_pkg::POS_LEN_LO)
            begin
                last_index = {last_index[7:0], b, 2'b11};
                need = block_start() + int'(rpt_count) * rtcp_pkg::REPORT_BLOCK_BYTES;
                if (status == rtcp_pkg::ST_OK && is_report() && need - 1 > int'(last_index))
                    status = rtcp_pkg::ST_OVERFLOW;
            end
            else if (pos <= rtcp_pkg::POS_SSRC_LAST)
                sender = {sender[23:0], b};
            else if (status == rtcp_pkg::ST_OK && is_report() && int'(pos) >= block_start()
                     && blocks_done < rpt_count)
            begin
                off = int'(pos) - block_start()
                    - int'(blocks_done) * rtcp_pkg::REPORT_BLOCK_BYTES;
                if (off >= 0 && off < rtcp_pkg::REPORT_BLOCK_BYTES)
                begin
                    blk[off] = b;
                    if (off == rtcp_pkg::REPORT_BLOCK_BYTES - 1)
                    begin
                        blocks_done++;
                        if (word(0) != 0)
                        begin
                            w1  = word(4);
                            res = '0;
                            res.result_kind        = rtcp_pkg::KIND_BLOCK;
                            res.sender_source      = sender;
                            res.block_source       = word(0);
                            res.fraction_lost      = w1[31:24];
                            res.cumulative_lost    = w1[23:0];
                            res.highest_sequence   = word(8);
                            res.arrival_jitter     = word(12);
                            res.last_sender_report = word(16);
                            res.delay_since_report = word(20);
                            res.packet_status      = rtcp_pkg::ST_OK;
                            res.blocks_declared    = rpt_count;
                            res.last_of_run        = !d.end_of_packet;
                            results_due.push_back(res);
                        end
                    end
                end
            end

            if (d.end_of_packet)
            begin
                trunc = (pos < rtcp_pkg::POS_SSRC_LAST) || (pos < last_index);
                res = '0;
                res.result_kind     = rtcp_pkg::KIND_STATUS;
                res.sender_source   = sender;
                res.packet_status   = status;
                if (status != rtcp_pkg::ST_BAD_VERSION && status != rtcp_pkg::ST_BAD_TYPE
                    && trunc)
                    res.packet_status = rtcp_pkg::ST_TRUNCATED;
                res.blocks_declared = rpt_count;
                res.last_of_run     = 1'b1;
                results_due.push_back(res);
                clear_packet();
            end
            else if (pos < rtcp_pkg::POS_MAX)
                pos++;
        endfunction

        function void cmp(string name, logic [31:0] e, logic [31:0] a);
            if (a !== e)
            begin
                $error("%s: expected %0h, actual %0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(rtcp_pkg::out_t a);
            rtcp_pkg::out_t e;
            if (results_due.size() == 0)
            begin
                $error("unexpected result, kind %0d status %0d", a.result_kind,
                       a.packet_status);
                errors++;
                return;
            end
            e = results_due.pop_front();
            cmp("result_kind", 32'(e.result_kind), 32'(a.result_kind));
            cmp("sender_source", e.sender_source, a.sender_source);
            cmp("block_source", e.block_source, a.block_source);
            cmp("fraction_lost", 32'(e.fraction_lost), 32'(a.fraction_lost));
            cmp("cumulative_lost", 32'(e.cumulative_lost), 32'(a.cumulative_lost));
            cmp("highest_sequence", e.highest_sequence, a.highest_sequence);
            cmp("arrival_jitter", e.arrival_jitter, a.arrival_jitter);
            cmp("last_sender_report", e.last_sender_report, a.last_sender_report);
            cmp("delay_since_report", e.delay_since_report, a.delay_since_report);
            cmp("packet_status", 32'(e.packet_status), 32'(a.packet_status));
            cmp("blocks_declared", 32'(e.blocks_declared), 32'(a.blocks_declared));
            cmp("last_of_run", 32'(e.last_of_run), 32'(a.last_of_run));
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           byte_valid;
    logic           byte_stall;
    rtcp_pkg::in_t  byte_data;
    logic           result_valid;
    logic           result_stall;
    rtcp_pkg::out_t result_data;

    report_tracker sb = new();
    logic [7:0]    pkt[$];
    bit            quiet = 1'b0;
    int            bytes_sent = 0;
    int            results_seen = 0;
    int            hold_left = 0;
    int            cycle_count = 0;

    rtcp_report_parser u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_data    (byte_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_beat(logic [7:0] b, logic last);
        rtcp_pkg::in_t d;
        d.packet_byte   = b;
        d.end_of_packet = last;
        byte_valid <= 1'b1;
        byte_data  <= d;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
        sb.note_byte(d);
        bytes_sent++;
        while (!quiet && $urandom_range(99) < 34)
        begin
            byte_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_packet(int n, bit close);
        for (int i = 0; i < n; i++)
            send_beat(pkt[i], close && i == n - 1);
    endtask

    task automatic add_random(int n);
        for (int i = 0; i < n; i++)
            pkt.push_back(8'($urandom));
    endtask

    task automatic start_header(logic [1:0] ver, logic [4:0] cnt, logic [7:0] ptype,
                                logic [15:0] lenw);
        logic [31:0] ssrc;
        ssrc = ($urandom_range(7) == 0) ? 32'd0 : 32'($urandom);
        pkt.delete();
        pkt.push_back({ver, 1'($urandom), cnt});
        pkt.push_back(ptype);
        pkt.push_back(lenw[15:8]);
        pkt.push_back(lenw[7:0]);
        for (int i = 3; i >= 0; i--)
            pkt.push_back(ssrc[i * 8 +: 8]);
    endtask

    task automatic make_report(logic [7:0] ptype, int cnt);
        int          total;
        logic [31:0] src;
        total = 8 + ((ptype == rtcp_pkg::TYPE_SR) ? rtcp_pkg::SENDER_INFO_BYTES : 0)
              + cnt * rtcp_pkg::REPORT_BLOCK_BYTES;
        start_header(rtcp_pkg::RTP_VERSION, 5'(cnt), ptype, 16'(total / 4 - 1));
        if (ptype == rtcp_pkg::TYPE_SR)
            add_random(rtcp_pkg::SENDER_INFO_BYTES);
        for (int i = 0; i < cnt; i++)
        begin
            // some blocks carry a zero source and must be dropped
            src = ($urandom_range(5) == 0) ? 32'd0 : 32'($urandom);
            for (int j = 3; j >= 0; j--)
                pkt.push_back(src[j * 8 +: 8]);
            add_random(rtcp_pkg::REPORT_BLOCK_BYTES - 4);
        end
    endtask

    // result side: random stall plus one long hold-off
    initial
    begin
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                sb.check_result(result_data);
                results_seen++;
                if (results_seen == 60)
                    hold_left = 400;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else
                result_stall <= !quiet && ($urandom_range(99) < 34);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        int          sel;
        int          cnt;
        int          k;
        int          total;
        logic [7:0]  ptype;
        logic [1:0]  ver;
        logic [15:0] lenw;

        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // one-byte packet, bad version, full report count
        pkt = '{8'hFF};
        send_packet(pkt.size(), 1);
        // bad type, ends inside the header
        pkt = '{8'h80, 8'd100, 8'h00};
        send_packet(pkt.size(), 1);
        // minimal receiver report
        pkt = '{8'h80, rtcp_pkg::TYPE_RR, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_packet(pkt.size(), 1);
        // valid other type cut inside the header
        pkt = '{8'h80, rtcp_pkg::TYPE_MAX, 8'h00, 8'h02, 8'hAB};
        send_packet(pkt.size(), 1);
        // sender report whose block does not fit the length
        pkt = '{8'h81, rtcp_pkg::TYPE_SR, 8'h00, 8'h01, 8'h12, 8'h34, 8'h56, 8'h78};
        send_packet(pkt.size(), 1);

        while (bytes_sent < ITEMS)
        begin
            // last quarter runs with no idling on either side
            if (bytes_sent >= ITEMS - ITEMS / 4)
                quiet = 1'b1;
            sel   = $urandom_range(99);
            cnt   = ($urandom_range(19) == 0) ? $urandom_range(4, 31) : $urandom_range(3);
            ptype = $urandom_range(1) ? rtcp_pkg::TYPE_SR : rtcp_pkg::TYPE_RR;
            if (sel < 62)
            begin
                make_report(ptype, cnt);
                send_packet(pkt.size(), 1);
            end
            else if (sel < 68)
            begin
                // trailing bytes past the declared length
                make_report(ptype, cnt);
                add_random($urandom_range(1, 8));
                send_packet(pkt.size(), 1);
            end
            else if (sel < 74)
            begin
                make_report(ptype, cnt);
                send_packet($urandom_range(1, pkt.size() - 1), 1);
            end
            else if (sel < 78)
            begin
                // length too short for the declared blocks
                cnt = $urandom_range(31);
                start_header(rtcp_pkg::RTP_VERSION, 5'(cnt), ptype,
                             16'($urandom_range(cnt * 6)));
                add_random($urandom_range(40));
                send_packet(pkt.size(), 1);
            end
            else if (sel < 82)
            begin
                ver = 2'($urandom_range(3));
                if (ver == rtcp_pkg::RTP_VERSION)
                    ver = 2'd3;
                start_header(ver, 5'($urandom), 8'($urandom), 16'($urandom));
                add_random($urandom_range(20));
                send_packet($urandom_range(1, pkt.size()), 1);
            end
            else if (sel < 86)
            begin
                ptype = 8'($urandom);
                while (ptype >= rtcp_pkg::TYPE_MIN && ptype <= rtcp_pkg::TYPE_MAX)
                    ptype = 8'($urandom);
                start_header(rtcp_pkg::RTP_VERSION, 5'($urandom), ptype, 16'($urandom));
                add_random($urandom_range(20));
                send_packet($urandom_range(2, pkt.size()), 1);
            end
            else if (sel < 91)
            begin
                // valid type that carries no report blocks
                lenw = 16'($urandom_range(6));
                start_header(rtcp_pkg::RTP_VERSION, 5'($urandom),
                             8'($urandom_range(202, 207)), lenw);
                add_random($urandom_range(int'(lenw) * 4 + 4));
                send_packet(pkt.size(), 1);
            end
            else if (sel < 95)
            begin
                pkt.delete();
                add_random($urandom_range(1, 12));
                send_packet(pkt.size(), 1);
            end
            else
            begin
                // length declares more than the blocks, padded or cut short
                make_report(ptype, cnt);
                total = pkt.size();
                k     = $urandom_range(1, 3);
                lenw  = 16'(total / 4 - 1 + k);
                pkt[2] = lenw[15:8];
                pkt[3] = lenw[7:0];
                add_random($urandom_range(k * 4));
                send_packet(pkt.size(), 1);
            end
        end
        byte_valid <= 1'b0;

        while (sb.results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/rtcp_pkg.sv
sv/rtcp_front.sv
sv/rtcp_queue.sv
sv/rtcp_back.sv
sv/rtcp_report_parser.sv
test/rtcp_report_parser_tb.sv
